FILE: src/pci_pkg.sv
// Package for the piecewise cubic interpolator: item and result word types,
// status codes, command codes and default sizes. No dependencies.
`default_nettype none

package pci_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [10:0] POINT_COUNT_RST = 11'd4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIV_ERR = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [9:0]         point_index;
        logic signed [31:0] abscissa;
        logic signed [31:0] ordinate;
        logic signed [31:0] query_point;
    } item_t;

    typedef struct packed {
        logic signed [31:0] interpolated_value;
        logic [1:0]         status;
    } result_t;

endpackage

`default_nettype wire

FILE: src/piecewise_cubic_interpolator_core.sv
// Top level of the piecewise cubic Lagrange interpolator: point table memory,
// window search and a shared serial divider / 31x31 multiplier sequencer.
// Depends on pci_pkg for word types, codes and default sizes.
//
//   channel   | ports                   | handshake
//   ----------+-------------------------+-----------------------------------
//   item in   | start, busy, item       | taken at an edge with start & !busy
//   result    | done, result            | done high one cycle, always taken
//   config    | cfg_we, cfg_data        | point_count written when cfg_we
//
// A table write leaves busy low. A query runs a table search, fetches the
// four-point window, then does the arithmetic: each ratio is one bit per cycle
// through the restoring divider plus set-up, each product four passes of the
// 31x31 multiplier. Reset clears the sequencer and sets point_count to 4; the
// table is not cleared. The receiver cannot stall the result.
`default_nettype none

module piecewise_cubic_interpolator_core #(
    parameter int MAX_POINTS = pci_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = pci_pkg::FRAC_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire pci_pkg::item_t  item,
    output logic                 done,
    output pci_pkg::result_t     result,
    input  wire logic            cfg_we,
    input  wire logic [10:0]     cfg_data
);

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int NW  = 33 + FRAC_BITS;
    localparam int CW  = $clog2(NW + 1);
    localparam logic [61:0] CAP = '1;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_LOW   = 13'b0000000000010,
        S_HIGH  = 13'b0000000000100,
        S_BIN   = 13'b0000000001000,
        S_LOAD  = 13'b0000000010000,
        S_CHECK = 13'b0000000100000,
        S_DSET  = 13'b0000001000000,
        S_DIV   = 13'b0000010000000,
        S_DFIN  = 13'b0000100000000,
        S_MUL   = 13'b0001000000000,
        S_MFIN  = 13'b0010000000000,
        S_TSET  = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } state_t;

    state_t             state_reg;
    logic [10:0]        pc_reg;
    logic               done_reg;
    pci_pkg::result_t   result_reg;

    // point table: abscissa in the upper half, ordinate in the lower
    logic [63:0]        point_mem [MAX_POINTS];
    logic [63:0]        rd_q_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic               rd_ok_reg;

    logic signed [31:0] p_reg;
    logic [PCW-1:0]     n_reg;
    logic [AW-1:0]      lo_reg;
    logic [AW-1:0]      hi_reg;
    logic [AW-1:0]      base_reg;
    logic [1:0]         k_reg;
    logic signed [31:0] xs_reg [4];
    logic signed [31:0] fs_reg [4];
    logic [1:0]         i_reg;
    logic [1:0]         j_reg;

    logic [NW-1:0]      num_reg;
    logic [33:0]        rem_reg;
    logic [32:0]        den_reg;
    logic               dsign_reg;
    logic [CW-1:0]      cnt_reg;

    logic [61:0]        ell_mag_reg;
    logic               ell_sgn_reg;
    logic [61:0]        opa_reg;
    logic [61:0]        opb_reg;
    logic               msign_reg;
    logic [123:0]       acc_reg;
    logic [1:0]         mcnt_reg;
    logic               mret_term_reg;
    logic signed [63:0] sum_reg;
    logic               sat_reg;

    logic               accept;
    logic [PCW-1:0]     n_clamp;
    logic [AW-1:0]      nm2;
    logic [AW-1:0]      nm4;
    logic signed [31:0] rd_x;
    logic               p_lt;
    logic [AW:0]        first_mid;
    logic [AW-1:0]      bin_lo;
    logic [AW-1:0]      bin_hi;
    logic [AW:0]        bin_sum;
    logic               bin_more;
    logic               eq_any;
    logic signed [32:0] d_full;
    logic signed [32:0] e_full;
    logic [32:0]        d_mag;
    logic [32:0]        e_mag;
    logic [33:0]        trial;
    logic [33:0]        rem_sh;
    logic [63:0]        q64;
    logic               qsat;
    logic [61:0]        qmag;
    logic [30:0]        a_part;
    logic [30:0]        b_part;
    logic [61:0]        pp;
    logic [123:0]       pp_sh;
    logic [123:0]       prod_sh;
    logic               msat;
    logic [61:0]        mmag;
    logic               msgn;
    logic signed [63:0] term;
    logic signed [63:0] sum_raw;
    logic signed [63:0] sum_new;
    logic               add_sat;
    logic [31:0]        fj_mag;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // clamp the point count into the usable range
    always_comb
    begin
        if (int'(pc_reg) < 4)
            n_clamp = PCW'(4);
        else if (int'(pc_reg) > MAX_POINTS)
            n_clamp = PCW'(MAX_POINTS);
        else
            n_clamp = PCW'(pc_reg);
    end

    assign nm2  = AW'(n_reg - PCW'(2));
    assign nm4  = AW'(n_reg - PCW'(4));
    assign rd_x = rd_q_reg[63:32];
    assign p_lt = (p_reg < rd_x);

    // binary search step
    assign first_mid = ((AW+1)'(1) + (AW+1)'(nm2)) >> 1;
    assign bin_lo    = p_lt ? lo_reg : rd_addr_reg;
    assign bin_hi    = p_lt ? rd_addr_reg : hi_reg;
    assign bin_sum   = (AW+1)'(bin_lo) + (AW+1)'(bin_hi);
    assign bin_more  = ((AW+1)'(bin_lo) + (AW+1)'(1)) < (AW+1)'(bin_hi);

    // any two window abscissas equal
    assign eq_any = (xs_reg[0] == xs_reg[1]) || (xs_reg[0] == xs_reg[2])
                 || (xs_reg[0] == xs_reg[3]) || (xs_reg[1] == xs_reg[2])
                 || (xs_reg[1] == xs_reg[3]) || (xs_reg[2] == xs_reg[3]);

    // ratio operands
    assign d_full = 33'(p_reg) - 33'(xs_reg[i_reg]);
    assign e_full = 33'(xs_reg[j_reg]) - 33'(xs_reg[i_reg]);
    assign d_mag  = d_full[32] ? 33'(-d_full) : 33'(d_full);
    assign e_mag  = e_full[32] ? 33'(-e_full) : 33'(e_full);

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {rem_reg[32:0], num_reg[NW-1]};
    assign trial  = rem_sh - {1'b0, den_reg};
    assign q64    = 64'(num_reg);
    assign qsat   = |q64[63:62];
    assign qmag   = qsat ? CAP : q64[61:0];

    // shared 31x31 multiplier, four passes per 62x62 product
    assign a_part = mcnt_reg[0] ? opa_reg[61:31] : opa_reg[30:0];
    assign b_part = mcnt_reg[1] ? opb_reg[61:31] : opb_reg[30:0];
    assign pp     = 62'(a_part) * 62'(b_part);

    always_comb
    begin
        case (mcnt_reg)
            2'd0:    pp_sh = 124'(pp);
            2'd3:    pp_sh = 124'(pp) << 62;
            default: pp_sh = 124'(pp) << 31;
        endcase
    end

    assign prod_sh = acc_reg >> FRAC_BITS;
    assign msat    = |prod_sh[123:62];
    assign mmag    = msat ? CAP : prod_sh[61:0];
    assign msgn    = msign_reg && (|mmag);

    // running sum, clamped to the intermediate range
    assign term    = msgn ? -64'(mmag) : 64'(mmag);
    assign sum_raw = sum_reg + term;
    always_comb
    begin
        add_sat = 1'b0;
        sum_new = sum_raw;
        if (sum_raw > $signed(64'(CAP)))
        begin
            sum_new = $signed(64'(CAP));
            add_sat = 1'b1;
        end
        else if (sum_raw < -$signed(64'(CAP)))
        begin
            sum_new = -$signed(64'(CAP));
            add_sat = 1'b1;
        end
    end

    assign fj_mag = fs_reg[j_reg][31] ? 32'(-fs_reg[j_reg]) : 32'(fs_reg[j_reg]);

    // table memory: write on a write word, registered read
    always_ff @(posedge clk)
    begin
        if (accept && item.cmd == pci_pkg::CMD_WRITE && int'(item.point_index) < MAX_POINTS)
            point_mem[AW'(item.point_index)] <= {item.abscissa, item.ordinate};
        rd_q_reg <= point_mem[rd_addr_reg];
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= pci_pkg::POINT_COUNT_RST;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg  <= 1'b0;
            rd_ok_reg <= 1'b1;
            if (cfg_we)
                pc_reg <= cfg_data;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && item.cmd == pci_pkg::CMD_QUERY)
                    begin
                        p_reg       <= item.query_point;
                        n_reg       <= n_clamp;
                        rd_addr_reg <= AW'(1);
                        rd_ok_reg   <= 1'b0;
                        sat_reg     <= 1'b0;
                        state_reg   <= S_LOW;
                    end
                end

                // below the second point: first window
                S_LOW:
                begin
                    if (rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b0;
                        if (p_lt)
                        begin
                            base_reg    <= '0;
                            rd_addr_reg <= '0;
                            k_reg       <= '0;
                            state_reg   <= S_LOAD;
                        end
                        else
                        begin
                            rd_addr_reg <= nm2;
                            state_reg   <= S_HIGH;
                        end
                    end
                end

                // at or above the second-last point: last window
                S_HIGH:
                begin
                    if (rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b0;
                        if (!p_lt)
                        begin
                            base_reg    <= nm4;
                            rd_addr_reg <= nm4;
                            k_reg       <= '0;
                            state_reg   <= S_LOAD;
                        end
                        else if (nm2 > AW'(2))
                        begin
                            lo_reg      <= AW'(1);
                            hi_reg      <= nm2;
                            rd_addr_reg <= AW'(first_mid);
                            state_reg   <= S_BIN;
                        end
                        else
                        begin
                            base_reg    <= '0;
                            rd_addr_reg <= '0;
                            k_reg       <= '0;
                            state_reg   <= S_LOAD;
                        end
                    end
                end

                S_BIN:
                begin
                    if (rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b0;
                        lo_reg    <= bin_lo;
                        hi_reg    <= bin_hi;
                        if (bin_more)
                            rd_addr_reg <= AW'(bin_sum >> 1);
                        else
                        begin
                            base_reg    <= bin_lo - AW'(1);
                            rd_addr_reg <= bin_lo - AW'(1);
                            k_reg       <= '0;
                            state_reg   <= S_LOAD;
                        end
                    end
                end

                // fetch the four window points
                S_LOAD:
                begin
                    if (rd_ok_reg)
                    begin
                        rd_ok_reg      <= 1'b0;
                        xs_reg[k_reg]  <= rd_q_reg[63:32];
                        fs_reg[k_reg]  <= rd_q_reg[31:0];
                        rd_addr_reg    <= base_reg + AW'(k_reg) + AW'(1);
                        k_reg          <= k_reg + 2'd1;
                        if (k_reg == 2'd3)
                            state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    if (eq_any)
                    begin
                        result_reg.interpolated_value <= '0;
                        result_reg.status             <= pci_pkg::ST_DIV_ERR;
                        done_reg                      <= 1'b1;
                        state_reg                     <= S_IDLE;
                    end
                    else
                    begin
                        i_reg       <= '0;
                        j_reg       <= '0;
                        ell_mag_reg <= 62'(1) << FRAC_BITS;
                        ell_sgn_reg <= 1'b0;
                        sum_reg     <= '0;
                        state_reg   <= S_DSET;
                    end
                end

                // set up one ratio, skip the diagonal
                S_DSET:
                begin
                    if (i_reg == j_reg)
                    begin
                        if (i_reg == 2'd3)
                            state_reg <= S_TSET;
                        else
                            i_reg <= i_reg + 2'd1;
                    end
                    else
                    begin
                        num_reg   <= {d_mag, FRAC_BITS'(0)};
                        den_reg   <= e_mag;
                        rem_reg   <= '0;
                        dsign_reg <= d_full[32] ^ e_full[32];
                        cnt_reg   <= CW'(NW);
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    rem_reg <= trial[33] ? rem_sh : trial;
                    num_reg <= {num_reg[NW-2:0], !trial[33]};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_reg <= S_DFIN;
                end

                // saturate the ratio and multiply it into the weight
                S_DFIN:
                begin
                    sat_reg       <= sat_reg | qsat;
                    opa_reg       <= ell_mag_reg;
                    opb_reg       <= qmag;
                    msign_reg     <= ell_sgn_reg ^ (dsign_reg && (|qmag));
                    acc_reg       <= '0;
                    mcnt_reg      <= '0;
                    mret_term_reg <= 1'b0;
                    state_reg     <= S_MUL;
                end

                S_MUL:
                begin
                    acc_reg  <= acc_reg + pp_sh;
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd3)
                        state_reg <= S_MFIN;
                end

                S_MFIN:
                begin
                    if (!mret_term_reg)
                    begin
                        sat_reg     <= sat_reg | msat;
                        ell_mag_reg <= mmag;
                        ell_sgn_reg <= msgn;
                        if (i_reg == 2'd3)
                            state_reg <= S_TSET;
                        else
                        begin
                            i_reg     <= i_reg + 2'd1;
                            state_reg <= S_DSET;
                        end
                    end
                    else
                    begin
                        sat_reg <= sat_reg | msat | add_sat;
                        sum_reg <= sum_new;
                        if (j_reg == 2'd3)
                            state_reg <= S_FIN;
                        else
                        begin
                            j_reg       <= j_reg + 2'd1;
                            i_reg       <= '0;
                            ell_mag_reg <= 62'(1) << FRAC_BITS;
                            ell_sgn_reg <= 1'b0;
                            state_reg   <= S_DSET;
                        end
                    end
                end

                // term: ordinate times weight
                S_TSET:
                begin
                    opa_reg       <= 62'(fj_mag);
                    opb_reg       <= ell_mag_reg;
                    msign_reg     <= fs_reg[j_reg][31] ^ ell_sgn_reg;
                    acc_reg       <= '0;
                    mcnt_reg      <= '0;
                    mret_term_reg <= 1'b1;
                    state_reg     <= S_MUL;
                end

                // clamp to 32 bits and deliver
                S_FIN:
                begin
                    if (sum_reg > 64'sd2147483647)
                    begin
                        result_reg.interpolated_value <= 32'h7FFFFFFF;
                        result_reg.status             <= pci_pkg::ST_SAT;
                    end
                    else if (sum_reg < -64'sd2147483648)
                    begin
                        result_reg.interpolated_value <= 32'h80000000;
                        result_reg.status             <= pci_pkg::ST_SAT;
                    end
                    else
                    begin
                        result_reg.interpolated_value <= sum_reg[31:0];
                        result_reg.status             <= sat_reg ? pci_pkg::ST_SAT
                                                                 : pci_pkg::ST_OK;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
